FILE: hw/rtl/dpsc_pkg.sv
// Shared types, widths and constants of the dual PID speed controller.
package dpsc_pkg;

  localparam int unsigned SpeedW = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned SumW   = 32;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 5;

  localparam logic signed [SpeedW-1:0] NoPrevMark = -16'sd1000;
  localparam logic signed [GainW-1:0]  KpReset    = 16'sd256;
  localparam logic signed [GainW-1:0]  KiReset    = 16'sd0;
  localparam logic signed [GainW-1:0]  KdReset    = 16'sd0;

  typedef enum logic [2:0] {
    RegKpLeft  = 3'd0,
    RegKiLeft  = 3'd1,
    RegKdLeft  = 3'd2,
    RegKpRight = 3'd3,
    RegKiRight = 3'd4,
    RegKdRight = 3'd5
  } reg_idx_e;

  typedef enum logic {
    ModeStep  = 1'b0,
    ModeClear = 1'b1
  } mode_e;

endpackage

FILE: hw/rtl/dpsc_if.sv
// Valid/ready channels for control items and drive results.
interface dpsc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     mode;
  logic signed [dpsc_pkg::SpeedW-1:0]       target_left;
  logic signed [dpsc_pkg::SpeedW-1:0]       target_right;
  logic signed [dpsc_pkg::SpeedW-1:0]       measured_left;
  logic signed [dpsc_pkg::SpeedW-1:0]       measured_right;

  modport source (output valid, mode, target_left, target_right, measured_left,
                  measured_right, input ready);
  modport sink (input valid, mode, target_left, target_right, measured_left,
                measured_right, output ready);
endinterface

interface dpsc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [dpsc_pkg::SpeedW-1:0]       drive_left;
  logic signed [dpsc_pkg::SpeedW-1:0]       drive_right;

  modport source (output valid, drive_left, drive_right, input ready);
  modport sink (input valid, drive_left, drive_right, output ready);
endinterface

FILE: hw/rtl/dual_pid_speed_controller_unit.sv
// The drive beat is offered once its control beat has passed from the error register through the
// product register to the result register; a stall at the output can hold it in any of them.
// Throughput: one beat per cycle while out_o.ready does not stall the chain; the loop state
// (errors, sums) updates in the accept cycle, so back-to-back beats see each other's state.
// A clear beat produces no result.
// Reset restores the default gains and the no-previous marker state at once.
module dual_pid_speed_controller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dpsc_in_if.sink                           in_i,
  dpsc_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dpsc_pkg::ApbAddrW-1:0]     paddr,
  input  logic [dpsc_pkg::ApbDataW-1:0]     pwdata,
  output logic [dpsc_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned SW = dpsc_pkg::SpeedW;
  localparam int unsigned GW = dpsc_pkg::GainW;
  localparam int unsigned AW = dpsc_pkg::SumW;
  localparam int unsigned PW = SW + GW;   // P and D product width
  localparam int unsigned IW = AW + GW;   // I product width
  localparam int unsigned TW = IW + 1;    // sum of the three products

  // Gain registers
  logic signed [GW-1:0] kp_l_q, ki_l_q, kd_l_q, kp_r_q, ki_r_q, kd_r_q;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_l_q <= dpsc_pkg::KpReset;
      ki_l_q <= dpsc_pkg::KiReset;
      kd_l_q <= dpsc_pkg::KdReset;
      kp_r_q <= dpsc_pkg::KpReset;
      ki_r_q <= dpsc_pkg::KiReset;
      kd_r_q <= dpsc_pkg::KdReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        dpsc_pkg::RegKpLeft:  kp_l_q <= pwdata[GW-1:0];
        dpsc_pkg::RegKiLeft:  ki_l_q <= pwdata[GW-1:0];
        dpsc_pkg::RegKdLeft:  kd_l_q <= pwdata[GW-1:0];
        dpsc_pkg::RegKpRight: kp_r_q <= pwdata[GW-1:0];
        dpsc_pkg::RegKiRight: ki_r_q <= pwdata[GW-1:0];
        dpsc_pkg::RegKdRight: kd_r_q <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dpsc_pkg::RegKpLeft:  prdata = {{(dpsc_pkg::ApbDataW-GW){kp_l_q[GW-1]}}, kp_l_q};
      dpsc_pkg::RegKiLeft:  prdata = {{(dpsc_pkg::ApbDataW-GW){ki_l_q[GW-1]}}, ki_l_q};
      dpsc_pkg::RegKdLeft:  prdata = {{(dpsc_pkg::ApbDataW-GW){kd_l_q[GW-1]}}, kd_l_q};
      dpsc_pkg::RegKpRight: prdata = {{(dpsc_pkg::ApbDataW-GW){kp_r_q[GW-1]}}, kp_r_q};
      dpsc_pkg::RegKiRight: prdata = {{(dpsc_pkg::ApbDataW-GW){ki_r_q[GW-1]}}, ki_r_q};
      dpsc_pkg::RegKdRight: prdata = {{(dpsc_pkg::ApbDataW-GW){kd_r_q[GW-1]}}, kd_r_q};
      default:              prdata = '0;
    endcase
  end

  // Saturating accumulate of a 16-bit error into a 32-bit sum.
  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] s,
                                                   input logic signed [SW-1:0] e);
    logic signed [AW:0] r;
    r = {s[AW-1], s} + {{(AW+1-SW){e[SW-1]}}, e};
    if (r[AW] != r[AW-1]) begin
      sat_add = r[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      sat_add = r[AW-1:0];
    end
  endfunction

  // Sum of the products, divided by 256 toward zero, saturated to 16 bits.
  function automatic logic signed [SW-1:0] finish(input logic signed [PW-1:0] p,
                                                  input logic signed [IW-1:0] i,
                                                  input logic signed [PW-1:0] d);
    logic signed [TW-1:0] acc;
    logic signed [TW-1:0] adj;
    logic signed [TW-9:0] q;
    acc = {{(TW-PW){p[PW-1]}}, p} + {{(TW-IW){i[IW-1]}}, i}
        + {{(TW-PW){d[PW-1]}}, d};
    adj = acc + (acc[TW-1] ? TW'(255) : TW'(0));
    q   = adj[TW-1:8];
    if (q > $signed((TW-8)'(32767))) begin
      finish = 16'sh7fff;
    end else if (q < -$signed((TW-8)'(32768))) begin
      finish = 16'sh8000;
    end else begin
      finish = q[SW-1:0];
    end
  endfunction

  // Handshake chain: each stage moves when it is empty or the next one moves.
  logic va_q, vb_q, vc_q;
  logic rdy_a, rdy_b, rdy_c, in_acc;

  assign rdy_c      = !vc_q || out_o.ready;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign in_i.ready = rdy_a;
  assign in_acc     = in_i.valid && rdy_a;
  assign out_o.valid = vc_q;

  // Loop state and the error stage
  logic signed [SW-1:0] last_err_l_q, last_err_r_q;
  logic signed [AW-1:0] sum_l_q, sum_r_q;
  logic signed [SW-1:0] err_l, err_r, diff_l, diff_r;
  logic signed [AW-1:0] sum_l_d, sum_r_d;
  logic                 have_prev, is_clear;

  assign is_clear  = (in_i.mode == dpsc_pkg::ModeClear);
  assign err_l     = in_i.target_left - in_i.measured_left;
  assign err_r     = in_i.target_right - in_i.measured_right;
  assign have_prev = (last_err_l_q != dpsc_pkg::NoPrevMark)
                  && (last_err_r_q != dpsc_pkg::NoPrevMark);
  assign diff_l    = have_prev ? SW'(err_l - last_err_l_q) : '0;
  assign diff_r    = have_prev ? SW'(err_r - last_err_r_q) : '0;
  assign sum_l_d   = sat_add(sum_l_q, err_l);
  assign sum_r_d   = sat_add(sum_r_q, err_r);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_l_q <= dpsc_pkg::NoPrevMark;
      last_err_r_q <= dpsc_pkg::NoPrevMark;
      sum_l_q      <= '0;
      sum_r_q      <= '0;
    end else if (in_acc) begin
      if (is_clear) begin
        last_err_l_q <= dpsc_pkg::NoPrevMark;
        last_err_r_q <= dpsc_pkg::NoPrevMark;
        sum_l_q      <= '0;
        sum_r_q      <= '0;
      end else begin
        last_err_l_q <= err_l;
        last_err_r_q <= err_r;
        sum_l_q      <= sum_l_d;
        sum_r_q      <= sum_r_d;
      end
    end
  end

  logic signed [SW-1:0] ea_l_q, ea_r_q, da_l_q, da_r_q;
  logic signed [AW-1:0] sa_l_q, sa_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= in_i.valid && !is_clear;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_clear) begin
      ea_l_q <= err_l;
      ea_r_q <= err_r;
      da_l_q <= diff_l;
      da_r_q <= diff_r;
      sa_l_q <= sum_l_d;
      sa_r_q <= sum_r_d;
    end
  end

  // Product stage
  logic signed [PW-1:0] pp_l_q, pd_l_q, pp_r_q, pd_r_q;
  logic signed [IW-1:0] pi_l_q, pi_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      pp_l_q <= kp_l_q * ea_l_q;
      pi_l_q <= ki_l_q * sa_l_q;
      pd_l_q <= kd_l_q * da_l_q;
      pp_r_q <= kp_r_q * ea_r_q;
      pi_r_q <= ki_r_q * sa_r_q;
      pd_r_q <= kd_r_q * da_r_q;
    end
  end

  // Result register
  logic signed [SW-1:0] drive_l_q, drive_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      drive_l_q <= finish(pp_l_q, pi_l_q, pd_l_q);
      drive_r_q <= finish(pp_r_q, pi_r_q, pd_r_q);
    end
  end

  assign out_o.drive_left  = drive_l_q;
  assign out_o.drive_right = drive_r_q;

  // A clear beat leaves the marker state and no work in the error stage.
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_clear |=> last_err_l_q == dpsc_pkg::NoPrevMark
      && last_err_r_q == dpsc_pkg::NoPrevMark && sum_l_q == '0 && sum_r_q == '0)
    else $error("loop state not cleared");

  a_clear_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_clear |=> !va_q)
    else $error("clear beat entered the pipeline");

  a_step_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_clear |=> va_q && ea_l_q == last_err_l_q
      && ea_r_q == last_err_r_q && sa_l_q == sum_l_q && sa_r_q == sum_r_q)
    else $error("error stage disagrees with loop state");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && !rdy_c |=> vb_q && $stable(pi_l_q) && $stable(pi_r_q))
    else $error("product stage lost a stalled beat");

endmodule
